/* hw/rtl/ucs_pkg.sv */
// Shared constants and types for the URI component splitter.
package ucs_pkg;

    localparam int DEF_POS_BITS = 16;
    localparam int KIND_COUNT   = 8;
    localparam int OUT_BITS     = 16;

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_COLON    = 8'h3A;

    typedef enum logic [2:0] {
        KIND_SCHEME   = 3'd0,
        KIND_USER     = 3'd1,
        KIND_PASSWORD = 3'd2,
        KIND_HOST     = 3'd3,
        KIND_PORT     = 3'd4,
        KIND_PATH     = 3'd5,
        KIND_QUERY    = 3'd6,
        KIND_FRAGMENT = 3'd7
    } t_kind;

endpackage

/* hw/rtl/ucs_if.sv */
// Valid/ready channel interfaces for the byte input and the component output.
interface ucs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_uri;

    modport source (output valid, output data_byte, output end_of_uri, input ready);
    modport sink   (input valid, input data_byte, input end_of_uri, output ready);
endinterface

interface ucs_out_if import ucs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          component_kind;
    logic [OUT_BITS-1:0] component_start;
    logic [OUT_BITS-1:0] component_length;
    logic                length_overflow;
    logic                final_component;

    modport source (output valid, output component_kind, output component_start,
                    output component_length, output length_overflow,
                    output final_component, input ready);
    modport sink   (input valid, input component_kind, input component_start,
                    input component_length, input length_overflow,
                    input final_component, output ready);
endinterface

/* hw/rtl/uri_component_splitter_top.sv */
// URI component splitter: byte parser, finished-record queue and result emitter.
//
// Usage:
//   i_in carries one URI byte per transaction; end_of_uri marks the last byte.
//   o_out carries one transaction per present component of a finished URI, in
//   kind order (scheme, user, password, host, port, path, query, fragment).
//   The path is always present; final_component marks the last one.
// Throughput and queueing:
//   The parser takes one byte every cycle while i_in.ready is high. A URI's
//   record enters the idle emitter as its last byte is accepted; its first
//   result then goes to the output register, and the results follow one per
//   cycle while o_out.ready is high, one to eight of them. One more record
//   may wait in a pending slot; i_in.ready drops only while it is occupied,
//   which happens when a URI ends before the emitter drains the previous one.
// Reset:
//   i_rst_n (synchronous, active low) clears the parser to the first-byte
//   state, empties the emitter and pending slot, and drops o_out.valid.
// Stall:
//   While o_out.ready is low the result holds in the output register and the
//   emitter waits; parsing of further bytes goes on until the pending slot
//   fills.
module uri_component_splitter_top import ucs_pkg::*; #(
    parameter int POS_BITS = DEF_POS_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucs_in_if.sink     i_in,
    ucs_out_if.source  o_out
);

    localparam int PW = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef struct packed {
        logic [KIND_COUNT-1:0] mask;
        logic [KIND_COUNT-1:0] flag;
        t_pos [KIND_COUNT-1:0] start;
        t_pos [KIND_COUNT-1:0] stop;
    } t_rec;

    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_SCHEME = 7'b0000010,
        PH_LOOK   = 7'b0000100,
        PH_AUTH   = 7'b0001000,
        PH_PATH   = 7'b0010000,
        PH_QUERY  = 7'b0100000,
        PH_FRAG   = 7'b1000000
    } t_phase;

    function automatic t_pos sat_inc(t_pos p);
        return (p == '1) ? p : p + 1'b1;
    endfunction

    // parser state
    t_phase     r_phase, n_phase;
    t_pos       r_pos;
    logic [1:0] r_look, n_look;
    t_pos       r_se, n_se;
    t_pos       r_a0, n_a0, r_a1, n_a1;
    t_pos       r_at, n_at, r_c0, n_c0, r_c1, n_c1;
    logic       r_at_seen, n_at_seen, r_c0_seen, n_c0_seen, r_c1_seen, n_c1_seen;
    t_pos       r_p0, n_p0, r_p1, n_p1, r_q0, n_q0, r_q1, n_q1;
    t_pos       r_fb, n_fb;
    logic       r_has_sch, n_has_sch, r_has_auth, n_has_auth;
    logic       r_has_q, n_has_q, r_has_f, n_has_f;
    logic       r_ovf;

    // emitter and queue
    t_rec            r_em, r_pend, new_rec;
    logic            r_pend_valid;
    logic            r_ov;
    t_kind           r_o_kind;
    logic [OUT_BITS-1:0] r_o_start, r_o_len;
    logic            r_o_ovf, r_o_final;

    logic       in_take, fin, em_busy, adv, em_last, em_free;
    logic [7:0] b;
    t_pos       cur, sat_cur;
    logic       do_path, do_auth;
    logic       is_slash, is_q, is_hash, is_at, is_colon;

    assign in_take  = i_in.valid && i_in.ready;
    assign fin      = in_take && i_in.end_of_uri;
    assign b        = i_in.data_byte;
    assign cur      = r_pos;
    assign sat_cur  = sat_inc(r_pos);
    assign is_slash = (b == CH_SLASH);
    assign is_q     = (b == CH_QUESTION);
    assign is_hash  = (b == CH_HASH);
    assign is_at    = (b == CH_AT);
    assign is_colon = (b == CH_COLON);

    always_comb begin
        n_phase = r_phase;  n_look = r_look;  n_se = r_se;
        n_a0 = r_a0;  n_a1 = r_a1;
        n_at = r_at;  n_c0 = r_c0;  n_c1 = r_c1;
        n_at_seen = r_at_seen;  n_c0_seen = r_c0_seen;  n_c1_seen = r_c1_seen;
        n_p0 = r_p0;  n_p1 = r_p1;  n_q0 = r_q0;  n_q1 = r_q1;  n_fb = r_fb;
        n_has_sch = r_has_sch;  n_has_auth = r_has_auth;
        n_has_q = r_has_q;  n_has_f = r_has_f;
        do_path = 1'b0;
        do_auth = 1'b0;

        unique case (r_phase)
            PH_FIRST: begin
                if (is_slash) begin
                    n_p0    = '0;
                    n_look  = 2'd1;
                    n_phase = PH_LOOK;
                end else begin
                    n_has_sch = 1'b1;
                    if (is_colon) begin
                        n_se    = cur;
                        n_p0    = sat_cur;
                        n_look  = 2'd0;
                        n_phase = PH_LOOK;
                    end else begin
                        n_phase = PH_SCHEME;
                    end
                end
            end
            PH_SCHEME: begin
                if (is_colon) begin
                    n_se    = cur;
                    n_p0    = sat_cur;
                    n_look  = 2'd0;
                    n_phase = PH_LOOK;
                end
            end
            PH_LOOK: begin
                if (r_look < 2'd2) begin
                    if (is_slash) n_look = r_look + 2'd1;
                    else          do_path = 1'b1;
                end else if (!is_slash) begin
                    n_a0       = cur;
                    n_has_auth = 1'b1;
                    n_phase    = PH_AUTH;
                    do_auth    = 1'b1;
                end else begin
                    do_path = 1'b1;
                end
            end
            PH_AUTH:  do_auth = 1'b1;
            PH_PATH:  do_path = 1'b1;
            PH_QUERY: begin
                if (is_hash) begin
                    n_q1    = cur;
                    n_fb    = sat_cur;
                    n_has_f = 1'b1;
                    n_phase = PH_FRAG;
                end
            end
            PH_FRAG: ;
            default: ;
        endcase

        if (do_auth) begin
            if (is_q || is_slash || is_hash) begin
                n_a1    = cur;
                n_p0    = cur;
                do_path = 1'b1;
            end else if (is_at) begin
                if (!r_at_seen) begin
                    n_at      = cur;
                    n_at_seen = 1'b1;
                end
            end else if (is_colon) begin
                if (!r_at_seen) begin
                    if (!r_c0_seen) begin
                        n_c0      = cur;
                        n_c0_seen = 1'b1;
                    end
                end else if (!r_c1_seen) begin
                    n_c1      = cur;
                    n_c1_seen = 1'b1;
                end
            end
        end

        if (do_path) begin
            n_phase = PH_PATH;
            if (is_q) begin
                n_p1    = cur;
                n_q0    = sat_cur;
                n_has_q = 1'b1;
                n_phase = PH_QUERY;
            end else if (is_hash) begin
                n_p1    = cur;
                n_fb    = sat_cur;
                n_has_f = 1'b1;
                n_phase = PH_FRAG;
            end
        end
    end

    // close the open component on the last byte and build the result record
    t_pos f_se, f_a1, f_p0, f_p1, f_q1, hc, hend, hstart, uend;
    logic hc_seen, f_ovf, c0x, atx, hcx;

    always_comb begin
        f_se = n_se;  f_a1 = n_a1;  f_p0 = n_p0;  f_p1 = n_p1;  f_q1 = n_q1;
        case (n_phase)
            PH_SCHEME: begin
                f_se = sat_cur;  f_p0 = sat_cur;  f_p1 = sat_cur;
            end
            PH_LOOK, PH_PATH: f_p1 = sat_cur;
            PH_AUTH: begin
                f_a1 = sat_cur;  f_p0 = sat_cur;  f_p1 = sat_cur;
            end
            PH_QUERY: f_q1 = sat_cur;
            default: ;
        endcase

        f_ovf   = r_ovf || (cur == '1);
        hc      = n_at_seen ? n_c1 : n_c0;
        hc_seen = n_at_seen ? n_c1_seen : n_c0_seen;
        uend    = n_c0_seen ? n_c0 : n_at;
        hstart  = n_at_seen ? sat_inc(n_at) : n_a0;
        hend    = hc_seen ? hc : f_a1;
        c0x     = n_has_auth && n_at_seen && n_c0_seen && (n_c0 == '1);
        atx     = n_has_auth && n_at_seen && (n_at == '1);
        hcx     = n_has_auth && hc_seen && (hc == '1);

        new_rec.start[KIND_SCHEME]   = '0;
        new_rec.stop[KIND_SCHEME]    = f_se;
        new_rec.start[KIND_USER]     = n_a0;
        new_rec.stop[KIND_USER]      = uend;
        new_rec.start[KIND_PASSWORD] = sat_inc(n_c0);
        new_rec.stop[KIND_PASSWORD]  = n_at;
        new_rec.start[KIND_HOST]     = hstart;
        new_rec.stop[KIND_HOST]      = hend;
        new_rec.start[KIND_PORT]     = sat_inc(hc);
        new_rec.stop[KIND_PORT]      = f_a1;
        new_rec.start[KIND_PATH]     = f_p0;
        new_rec.stop[KIND_PATH]      = f_p1;
        new_rec.start[KIND_QUERY]    = n_q0;
        new_rec.stop[KIND_QUERY]     = f_q1;
        new_rec.start[KIND_FRAGMENT] = n_fb;
        new_rec.stop[KIND_FRAGMENT]  = sat_cur;

        new_rec.mask[KIND_SCHEME]    = n_has_sch;
        new_rec.mask[KIND_USER]      = n_has_auth && n_at_seen;
        new_rec.mask[KIND_PASSWORD]  = n_has_auth && n_at_seen && n_c0_seen;
        new_rec.mask[KIND_HOST]      = n_has_auth;
        new_rec.mask[KIND_PORT]      = n_has_auth && hc_seen;
        new_rec.mask[KIND_PATH]      = 1'b1;
        new_rec.mask[KIND_QUERY]     = n_has_q;
        new_rec.mask[KIND_FRAGMENT]  = n_has_f;

        // saturated increments taken while building the record flag that result and all later ones
        for (int k = 0; k < KIND_COUNT; k++) begin
            new_rec.flag[k] = f_ovf || (k >= 2 && c0x) || (k >= 3 && atx) || (k >= 4 && hcx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_phase <= PH_FIRST;  r_pos <= '0;  r_look <= '0;  r_se <= '0;
            r_a0 <= '0;  r_a1 <= '0;  r_at <= '0;  r_c0 <= '0;  r_c1 <= '0;
            r_at_seen <= 1'b0;  r_c0_seen <= 1'b0;  r_c1_seen <= 1'b0;
            r_p0 <= '0;  r_p1 <= '0;  r_q0 <= '0;  r_q1 <= '0;  r_fb <= '0;
            r_has_sch <= 1'b0;  r_has_auth <= 1'b0;  r_has_q <= 1'b0;  r_has_f <= 1'b0;
            r_ovf <= 1'b0;
        end else if (in_take) begin
            r_phase <= n_phase;  r_pos <= sat_cur;  r_look <= n_look;  r_se <= n_se;
            r_a0 <= n_a0;  r_a1 <= n_a1;  r_at <= n_at;  r_c0 <= n_c0;  r_c1 <= n_c1;
            r_at_seen <= n_at_seen;  r_c0_seen <= n_c0_seen;  r_c1_seen <= n_c1_seen;
            r_p0 <= n_p0;  r_p1 <= n_p1;  r_q0 <= n_q0;  r_q1 <= n_q1;  r_fb <= n_fb;
            r_has_sch <= n_has_sch;  r_has_auth <= n_has_auth;
            r_has_q <= n_has_q;  r_has_f <= n_has_f;
            r_ovf <= f_ovf;
        end
    end

    // emitter: lowest set kind of the record goes out next
    logic [KIND_COUNT-1:0] low_bit;
    logic [2:0]            e_idx;
    t_pos                  e_start, e_stop, e_len;
    logic [PW-1:0]         s_w, l_w;
    logic                  clamp_s, clamp_l;

    assign em_busy = |r_em.mask;
    assign adv     = em_busy && (!r_ov || o_out.ready);
    assign low_bit = r_em.mask & (~r_em.mask + 1'b1);
    assign em_last = adv && (r_em.mask == low_bit);
    assign em_free = !em_busy || em_last;

    always_comb begin
        e_idx = '0;
        for (int i = KIND_COUNT - 1; i >= 0; i--) begin
            if (r_em.mask[i]) e_idx = 3'(i);
        end
    end

    assign e_start = r_em.start[e_idx];
    assign e_stop  = r_em.stop[e_idx];
    assign e_len   = (e_stop >= e_start) ? e_stop - e_start : '0;
    assign s_w     = PW'(e_start);
    assign l_w     = PW'(e_len);
    assign clamp_s = s_w > PW'({OUT_BITS{1'b1}});
    assign clamp_l = l_w > PW'({OUT_BITS{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em.mask    <= '0;
            r_pend_valid <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (em_free) begin
                if (r_pend_valid) begin
                    r_em.mask    <= r_pend.mask;
                    r_pend_valid <= fin;
                end else if (fin) begin
                    r_em.mask <= new_rec.mask;
                end else begin
                    r_em.mask <= '0;
                end
            end else begin
                if (adv) r_em.mask <= r_em.mask & ~low_bit;
                if (fin) r_pend_valid <= 1'b1;
            end
            if (adv)                r_ov <= 1'b1;
            else if (o_out.ready)   r_ov <= 1'b0;
        end
    end

    // record payload, no reset
    always_ff @(posedge i_clk) begin
        if (em_free) begin
            if (r_pend_valid) begin
                r_em.flag  <= r_pend.flag;
                r_em.start <= r_pend.start;
                r_em.stop  <= r_pend.stop;
            end else if (fin) begin
                r_em.flag  <= new_rec.flag;
                r_em.start <= new_rec.start;
                r_em.stop  <= new_rec.stop;
            end
        end
        if (fin) r_pend <= new_rec;
        if (adv) begin
            r_o_kind  <= t_kind'(e_idx);
            r_o_start <= clamp_s ? {OUT_BITS{1'b1}} : s_w[OUT_BITS-1:0];
            r_o_len   <= clamp_l ? {OUT_BITS{1'b1}} : l_w[OUT_BITS-1:0];
            r_o_ovf   <= r_em.flag[e_idx] || clamp_s || clamp_l;
            r_o_final <= em_last;
        end
    end

    assign i_in.ready             = !r_pend_valid;
    assign o_out.valid            = r_ov;
    assign o_out.component_kind   = r_o_kind;
    assign o_out.component_start  = r_o_start;
    assign o_out.component_length = r_o_len;
    assign o_out.length_overflow  = r_o_ovf;
    assign o_out.final_component  = r_o_final;

    a_pend_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> em_busy)
        else $error("pending record while emitter idle");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> em_busy)
        else $error("finished URI not queued for emission");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.final_component) |=> r_ov)
        else $error("gap inside a result burst");

    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_pos == '0 && !r_has_sch && !r_has_auth && !r_ovf))
        else $error("parser in first-byte phase with stale state");

endmodule
